>>> rtl/sha256_stream_hasher_core_assert.svh
// Assertion macros for the SHA-256 stream hasher.
// Included by the top level; no other dependencies.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sha256_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; used by sha256_round and the top level.
`default_nettype none

package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] vars_t;   // index 0 = a ... index 7 = h
    typedef word_t [0:15] sched_t; // index 0 = oldest word, MSBs of the block

    localparam vars_t H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: handshakes, byte packing, padding
// and round sequencer. Depends on sha256_pkg, sha256_round and the assert header.
//
//  channel | dir | tdata (low bit up)                      | tuser        | tlast
//  --------+-----+-----------------------------------------+--------------+------------
//  s_      | in  | [7:0] message_byte                      | byte_present | message_end
//  m_      | out | [31:0] digest_word, [34:32] word_index  | -            | last_word
//
// Flow: data transactions are taken while idle; the 64th byte of a block starts 64
// rounds on the single round unit, then a fold of the result into the hash.
// An end transaction then pushes one pad byte per cycle up to the block end
// (up to 64, or 72 with an extra block), each full block again going through the
// rounds and the fold, then eight digest transactions at the output's pace.
// Reset: aresetn, synchronous, active low; returns to the initial hash values.
// Stalls: s_tready is low outside the idle state; m_tready only gates digest words.
`default_nettype none
`include "sha256_stream_hasher_core_assert.svh"

module sha256_stream_hasher_core import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // message_end
    // digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // taking message bytes
        S_PAD  = 5'b00010,  // pushing marker, zero fill and length
        S_COMP = 5'b00100,  // 64 rounds
        S_FOLD = 5'b01000,  // add working vars into hash
        S_OUT  = 5'b10000   // emitting digest words
    } state_t;

    state_t      state_reg, state_next;
    vars_t       hash_reg, hash_next;
    vars_t       vars_reg, vars_next;
    sched_t      sched_reg, sched_next;    // doubles as the block buffer
    logic [5:0]  cnt_reg, cnt_next;        // bytes in current block
    logic [5:0]  rnd_reg, rnd_next;
    logic [60:0] len_reg, len_next;        // message length in bytes
    logic        end_pend_reg, end_pend_next;
    logic        pad_reg, pad_next;
    logic        marker_reg, marker_next;  // 0x80 still to push
    logic        len_ok_reg, len_ok_next;  // this block carries the length
    logic [2:0]  idx_reg, idx_next;

    vars_t       vars_rnd;
    word_t       w_new;
    logic        push_en;
    logic [7:0]  push_byte;
    logic [7:0]  len_byte;
    logic [63:0] len_bits;
    logic [519:0] shift_wide;

    sha256_round u_round (
        .rnd      (rnd_reg),
        .vars_in  (vars_reg),
        .sched_in (sched_reg),
        .vars_out (vars_rnd),
        .w_new    (w_new)
    );

    // big-endian length byte for block position 56 + cnt[2:0]
    assign len_bits = {len_reg, 3'b000};
    assign len_byte = len_bits[{~cnt_reg[2:0], 3'b000} +: 8];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'b00000, idx_reg, hash_reg[0]};
    assign m_tlast  = (idx_reg == 3'd7);

    always_comb begin
        state_next    = state_reg;
        hash_next     = hash_reg;
        vars_next     = vars_reg;
        sched_next    = sched_reg;
        cnt_next      = cnt_reg;
        rnd_next      = rnd_reg;
        len_next      = len_reg;
        end_pend_next = end_pend_reg;
        pad_next      = pad_reg;
        marker_next   = marker_reg;
        len_ok_next   = len_ok_reg;
        idx_next      = idx_reg;
        push_en       = 1'b0;
        push_byte     = 8'h00;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        push_en   = 1'b1;
                        push_byte = s_tdata;
                        len_next  = len_reg + 61'd1;
                    end
                    if (s_tuser && cnt_reg == 6'd63) begin
                        state_next    = S_COMP;
                        end_pend_next = s_tlast;
                    end else if (s_tlast) begin
                        state_next  = S_PAD;
                        pad_next    = 1'b1;
                        marker_next = 1'b1;
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                if (marker_reg) begin
                    push_byte   = PAD_MARKER;
                    marker_next = 1'b0;
                    len_ok_next = (cnt_reg < LEN_POS);
                end else if (len_ok_reg && cnt_reg >= LEN_POS) begin
                    push_byte = len_byte;
                end
                if (cnt_reg == 6'd63) begin
                    state_next = S_COMP;
                end
            end
            S_COMP: begin
                vars_next  = vars_rnd;
                sched_next = {sched_reg[1:15], w_new};
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                if (pad_reg) begin
                    if (len_ok_reg) begin
                        state_next = S_OUT;
                        idx_next   = 3'd0;
                    end else begin
                        // marker landed past the length field: one more block
                        len_ok_next = 1'b1;
                        state_next  = S_PAD;
                    end
                end else if (end_pend_reg) begin
                    end_pend_next = 1'b0;
                    pad_next      = 1'b1;
                    marker_next   = 1'b1;
                    state_next    = S_PAD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    hash_next = {hash_reg[0], hash_reg[7:1]};
                    idx_next  = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        hash_next   = H_INIT;
                        len_next    = '0;
                        pad_next    = 1'b0;
                        len_ok_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // byte push: block buffer shifts left one byte, new byte at the bottom
        shift_wide = {sched_reg, push_byte};
        if (push_en) begin
            sched_next = shift_wide[511:0];
            cnt_next   = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                vars_next = hash_reg;
                rnd_next  = 6'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hash_reg     <= H_INIT;
            cnt_reg      <= '0;
            rnd_reg      <= '0;
            len_reg      <= '0;
            end_pend_reg <= 1'b0;
            pad_reg      <= 1'b0;
            marker_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            hash_reg     <= hash_next;
            cnt_reg      <= cnt_next;
            rnd_reg      <= rnd_next;
            len_reg      <= len_next;
            end_pend_reg <= end_pend_next;
            pad_reg      <= pad_next;
            marker_reg   <= marker_next;
            len_ok_reg   <= len_ok_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        vars_reg  <= vars_next;
        sched_reg <= sched_next;
    end

    // digest words only go out once the final block is done and the buffer is empty
    `SHA_ASSERT_IMPL(a_out_empty_block, aclk, aresetn, m_tvalid, cnt_reg == 6'd0 && !s_tready, "digest with bytes pending")
    // rounds always start from round zero
    `SHA_ASSERT_IMPL(a_comp_start, aclk, aresetn, state_reg == S_COMP && $past(state_reg) != S_COMP, rnd_reg == 6'd0, "round count not zero at block start")
    // after the last digest word the block is ready for the next message
    `SHA_ASSERT_NEXT(a_ready_after_last, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready && len_reg == 61'd0, "not idle after digest")

endmodule

`default_nettype wire

>>> rtl/sha256_round.sv
// One SHA-256 round plus the matching message schedule step.
// Depends on sha256_pkg.
`default_nettype none

module sha256_round import sha256_pkg::*; (
    input  logic [5:0] rnd,
    input  vars_t      vars_in,
    input  sched_t     sched_in,
    output vars_t      vars_out,
    output word_t      w_new
);

    function automatic word_t ror(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    word_t a, b, c, d, e, f, g, h;
    word_t big_s0, big_s1, ch, maj, t1, t2;
    word_t sig0, sig1;

    always_comb begin
        a = vars_in[0]; b = vars_in[1]; c = vars_in[2]; d = vars_in[3];
        e = vars_in[4]; f = vars_in[5]; g = vars_in[6]; h = vars_in[7];

        big_s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
        big_s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
        ch     = (e & f) ^ (~e & g);
        maj    = (a & b) ^ (a & c) ^ (b & c);
        t1     = h + big_s1 + ch + round_k(rnd) + sched_in[0];
        t2     = big_s0 + maj;

        vars_out[0] = t1 + t2;
        vars_out[1] = a;
        vars_out[2] = b;
        vars_out[3] = c;
        vars_out[4] = d + t1;
        vars_out[5] = e;
        vars_out[6] = f;
        vars_out[7] = g;

        // W[t+16] from the window W[t..t+15]
        sig1  = ror(sched_in[14], 17) ^ ror(sched_in[14], 19) ^ (sched_in[14] >> 10);
        sig0  = ror(sched_in[1], 7) ^ ror(sched_in[1], 18) ^ (sched_in[1] >> 3);
        w_new = sig1 + sched_in[9] + sig0 + sched_in[0];
    end

endmodule

`default_nettype wire
